### sv/mvna_pkg.sv
// Shared types, field widths, item codes and small arithmetic helpers for the
// mesh vertex normal accumulator. Depends on nothing.
package mvna_pkg;

    // Item codes carried in the kind field.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_LOAD  = 2'd0;
    localparam kind_t KIND_TRI   = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;
    localparam kind_t KIND_CLEAR = 2'd3;

    localparam int IDX_W   = 8;   // vertex index field
    localparam int COORD_W = 24;  // position component, 8 fraction bits
    localparam int EDGE_W  = 25;  // difference of two positions
    localparam int PROD_W  = 49;  // product of an e1 and an e2 component
    localparam int VEC_W   = 51;  // cross product or accumulator magnitude
    localparam int ACC_W   = 22;  // accumulator component, Q8.14
    localparam int NRM_W   = 16;  // unit normal component, Q2.14
    localparam int MUL_W   = 32;  // shared multiplier operand
    localparam int SQ_W    = 63;  // sum of squares and square root work
    localparam int LEN_W   = 32;  // vector length after normalization
    localparam int Q_W     = 16;  // quotient bits per component

    localparam logic [Q_W-1:0] ONE_Q14 = 16'd16384;
    localparam logic signed [ACC_W:0] SUM_MAX = 23'sd2097151;
    localparam logic signed [ACC_W:0] SUM_MIN = -23'sd2097152;

    typedef logic [VEC_W-1:0] mag_t;

    // Magnitude of a signed vector component.
    function automatic mag_t mag_of(logic signed [VEC_W-1:0] v);
        mag_t r;
        r = v[VEC_W-1] ? mag_t'(-v) : mag_t'(v);
        return r;
    endfunction

    // Accumulator minus unit component, limited to the accumulator range.
    function automatic logic [ACC_W-1:0] sat_sub(logic signed [ACC_W-1:0] acc,
                                                 logic signed [NRM_W-1:0] d);
        logic signed [ACC_W:0] diff;
        logic [ACC_W-1:0] r;
        diff = (ACC_W+1)'(acc) - (ACC_W+1)'(d);
        if (diff > SUM_MAX)
            r = SUM_MAX[ACC_W-1:0];
        else if (diff < SUM_MIN)
            r = SUM_MIN[ACC_W-1:0];
        else
            r = diff[ACC_W-1:0];
        return r;
    endfunction

endpackage

### sv/mvna_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/mesh_vertex_normal_accumulator.sv
// Top level of the mesh vertex normal accumulator: vertex store, normal
// accumulators and the sequenced arithmetic. Uses mvna_pkg and mvna_ram.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, kind, vertex_index,   | into block
//           | second_index, third_index, coord_x/y/z    |
//   out     | out_valid, out_stall, normal_x/y/z        | out of block
//
// After acceptance a triangle or a read keeps in_stall high until the sequencer
// is done; a triangle whose cross product is zero, a zero accumulator and a read
// index out of range take shorter paths. How long it stays high varies with the
// one-bit-a-cycle normalizing shift, and the rest goes to one shared 32x32
// multiplier, a 32-step square root and three divisions. A clear item, and the
// pass that follows reset, sweep the accumulators, one accumulator entry a cycle.
// A finished read result sits in the output register, so a stalled output holds
// up the sequencer only when the next read result is ready before the previous
// one has been taken.
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
#(
    parameter int MAX_VERTICES = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [IDX_W-1:0]         vertex_index,
    input  logic [IDX_W-1:0]         second_index,
    input  logic [IDX_W-1:0]         third_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [NRM_W-1:0]  normal_x,
    output logic signed [NRM_W-1:0]  normal_y,
    output logic signed [NRM_W-1:0]  normal_z
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int LIMIT_W = 18;
    localparam logic [LIMIT_W-1:0] VTX_LIMIT = LIMIT_W'(MAX_VERTICES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

    // Sequencer states.
    localparam logic [4:0] S_CLEAR = 5'd0;   // zeroing pass over the accumulators
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_VA    = 5'd2;   // fetch corner a
    localparam logic [4:0] S_VB    = 5'd3;   // fetch corner b, hold a
    localparam logic [4:0] S_VC    = 5'd4;   // fetch corner c, form first edge
    localparam logic [4:0] S_VE    = 5'd5;   // form the edge from corner a to corner c
    localparam logic [4:0] S_CROSS = 5'd6;   // six products on the multiplier
    localparam logic [4:0] S_MAG   = 5'd7;   // largest magnitude
    localparam logic [4:0] S_NORM  = 5'd8;   // bring it into [2^29, 2^30)
    localparam logic [4:0] S_SQ    = 5'd9;   // sum of squares
    localparam logic [4:0] S_SQRT  = 5'd10;  // integer square root
    localparam logic [4:0] S_DIVI  = 5'd11;  // set up one component division
    localparam logic [4:0] S_DIV   = 5'd12;  // restoring division steps
    localparam logic [4:0] S_ACCRD = 5'd13;  // read one corner's accumulator
    localparam logic [4:0] S_ACCWR = 5'd14;  // write it back, saturated
    localparam logic [4:0] S_RDACC = 5'd15;  // read accumulator for a read item
    localparam logic [4:0] S_RDLD  = 5'd16;  // take its components
    localparam logic [4:0] S_OUT   = 5'd17;  // hand the result to the output

    logic [4:0] state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic [AW-1:0] corner_reg [3];
    logic [AW-1:0] corner_next [3];
    logic [AW-1:0] clr_reg, clr_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] comp_reg, comp_next;

    logic signed [COORD_W-1:0] pa_reg [3];
    logic signed [COORD_W-1:0] pa_next [3];
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e1_next [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [EDGE_W-1:0]  e2_next [3];
    logic signed [2*MUL_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0]  tmp_reg, tmp_next;
    mag_t       mag_reg [3];
    mag_t       mag_next [3];
    logic [2:0] sign_reg, sign_next;
    mag_t       m_reg, m_next;
    logic [SQ_W-1:0] n_reg, n_next;
    logic [SQ_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic [LEN_W-1:0] r_reg, r_next;
    logic [Q_W-1:0]   nlo_reg, nlo_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic signed [NRM_W-1:0] u_reg [3];
    logic signed [NRM_W-1:0] u_next [3];
    logic out_valid_reg, out_valid_next;
    logic signed [NRM_W-1:0] normal_x_reg, normal_x_next;
    logic signed [NRM_W-1:0] normal_y_reg, normal_y_next;
    logic signed [NRM_W-1:0] normal_z_reg, normal_z_next;

    logic in_accept;
    logic a_ok, b_ok, c_ok;

    logic vtx_we;
    logic [AW-1:0] vtx_raddr;
    logic [3*COORD_W-1:0] vtx_rdata;
    logic acc_we;
    logic [AW-1:0] acc_addr_sel;
    logic [AW-1:0] acc_waddr;
    logic [3*ACC_W-1:0] acc_wdata;
    logic [3*ACC_W-1:0] acc_rdata;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [1:0] sel_idx;
    mag_t       mag_sel;
    logic       sign_sel;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign a_ok = ({{(LIMIT_W-IDX_W){1'b0}}, vertex_index} < VTX_LIMIT);
    assign b_ok = ({{(LIMIT_W-IDX_W){1'b0}}, second_index} < VTX_LIMIT);
    assign c_ok = ({{(LIMIT_W-IDX_W){1'b0}}, third_index} < VTX_LIMIT);

    assign out_valid = out_valid_reg;
    assign normal_x  = normal_x_reg;
    assign normal_y  = normal_y_reg;
    assign normal_z  = normal_z_reg;

    // Vertex store: loads are written straight from the input port.
    assign vtx_we = in_accept && (kind == KIND_LOAD) && a_ok;

    always_comb
    begin
        case (state_reg)
            S_VA:    vtx_raddr = corner_reg[0];
            S_VB:    vtx_raddr = corner_reg[1];
            default: vtx_raddr = corner_reg[2];
        endcase
    end

    mvna_ram #(
        .WIDTH (3*COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (vtx_we),
        .waddr (AW'(vertex_index)),
        .wdata ({coord_z, coord_y, coord_x}),
        .raddr (vtx_raddr),
        .rdata (vtx_rdata)
    );

    // Accumulator store, read, and outside the clearing pass written, at the corner picked by comp_reg.
    always_comb
    begin
        case (comp_reg)
            2'd1:    acc_addr_sel = corner_reg[1];
            2'd2:    acc_addr_sel = corner_reg[2];
            default: acc_addr_sel = corner_reg[0];
        endcase
    end

    assign acc_we    = (state_reg == S_CLEAR) || (state_reg == S_ACCWR);
    assign acc_waddr = (state_reg == S_CLEAR) ? clr_reg : acc_addr_sel;
    assign acc_wdata = (state_reg == S_CLEAR) ? '0 :
        {sat_sub(acc_rdata[2*ACC_W +: ACC_W], u_reg[2]),
         sat_sub(acc_rdata[ACC_W +: ACC_W], u_reg[1]),
         sat_sub(acc_rdata[0 +: ACC_W], u_reg[0])};

    mvna_ram #(
        .WIDTH (3*ACC_W),
        .DEPTH (MAX_VERTICES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_addr_sel),
        .rdata (acc_rdata)
    );

    // Component select for squaring (by step) and division (by comp).
    assign sel_idx = (state_reg == S_SQ) ? step_reg[1:0] : comp_reg;

    always_comb
    begin
        case (sel_idx)
            2'd1:
            begin
                mag_sel  = mag_reg[1];
                sign_sel = sign_reg[1];
            end
            2'd2:
            begin
                mag_sel  = mag_reg[2];
                sign_sel = sign_reg[2];
            end
            default:
            begin
                mag_sel  = mag_reg[0];
                sign_sel = sign_reg[0];
            end
        endcase
    end

    // The one shared multiplier: cross product terms, then squares.
    always_comb
    begin
        mul_a = MUL_W'($signed({2'b00, mag_sel[29:0]}));
        mul_b = mul_a;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                5'd0:
                begin
                    mul_a = MUL_W'(e1_reg[1]);
                    mul_b = MUL_W'(e2_reg[2]);
                end
                5'd1:
                begin
                    mul_a = MUL_W'(e1_reg[2]);
                    mul_b = MUL_W'(e2_reg[1]);
                end
                5'd2:
                begin
                    mul_a = MUL_W'(e1_reg[2]);
                    mul_b = MUL_W'(e2_reg[0]);
                end
                5'd3:
                begin
                    mul_a = MUL_W'(e1_reg[0]);
                    mul_b = MUL_W'(e2_reg[2]);
                end
                5'd4:
                begin
                    mul_a = MUL_W'(e1_reg[0]);
                    mul_b = MUL_W'(e2_reg[1]);
                end
                default:
                begin
                    mul_a = MUL_W'(e1_reg[1]);
                    mul_b = MUL_W'(e2_reg[0]);
                end
            endcase
        end
        prod_next = mul_a * mul_b;
    end

    // Sequencer.
    always_comb
    begin
        logic [4:0] p;
        logic signed [VEC_W-1:0] cr;
        logic signed [VEC_W-1:0] av;
        mag_t m1, m2;
        logic [SQ_W-1:0] trial_root;
        logic [45:0] num;
        logic [LEN_W:0] trial, dval;
        logic [Q_W-1:0] qn, qc;

        state_next     = state_reg;
        kind_next      = kind_reg;
        corner_next    = corner_reg;
        clr_next       = clr_reg;
        step_next      = step_reg;
        comp_next      = comp_reg;
        pa_next        = pa_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        tmp_next       = tmp_reg;
        mag_next       = mag_reg;
        sign_next      = sign_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        r_next         = r_reg;
        nlo_next       = nlo_reg;
        q_next         = q_reg;
        u_next         = u_reg;
        normal_x_next  = normal_x_reg;
        normal_y_next  = normal_y_reg;
        normal_z_next  = normal_z_reg;
        out_valid_next = out_valid_reg && out_stall;

        p  = step_reg - 5'd1;
        cr = VEC_W'(tmp_reg) - VEC_W'($signed(prod_reg[VEC_W-1:0]));
        m1 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        m2 = (m1 > mag_reg[2]) ? m1 : mag_reg[2];
        trial_root = root_reg + bit_reg;
        num   = {1'b0, mag_sel[29:0], 15'd0} + 46'(root_reg[LEN_W-1:0]);
        dval  = {root_reg[LEN_W-1:0], 1'b0};
        trial = {r_reg, nlo_reg[Q_W-1]};
        qn    = {q_reg[Q_W-2:0], (trial >= dval)};
        qc    = (qn > ONE_Q14) ? ONE_Q14 : qn;
        av    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next      = kind;
                    corner_next[0] = AW'(vertex_index);
                    corner_next[1] = AW'(second_index);
                    corner_next[2] = AW'(third_index);
                    comp_next      = 2'd0;
                    case (kind)
                        KIND_TRI:
                        begin
                            if (a_ok && b_ok && c_ok)
                            begin
                                state_next = S_VA;
                            end
                        end
                        KIND_READ:
                        begin
                            if (a_ok)
                            begin
                                state_next = S_RDACC;
                            end
                            else
                            begin
                                u_next[0]  = '0;
                                u_next[1]  = '0;
                                u_next[2]  = '0;
                                state_next = S_OUT;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_VA:
            begin
                state_next = S_VB;
            end
            S_VB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pa_next[i] = $signed(vtx_rdata[i*COORD_W +: COORD_W]);
                end
                state_next = S_VC;
            end
            S_VC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_next[i] = EDGE_W'($signed(vtx_rdata[i*COORD_W +: COORD_W]))
                                 - EDGE_W'(pa_reg[i]);
                end
                state_next = S_VE;
            end
            S_VE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e2_next[i] = EDGE_W'($signed(vtx_rdata[i*COORD_W +: COORD_W]))
                                 - EDGE_W'(pa_reg[i]);
                end
                step_next  = 5'd0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                // The product issued last cycle is consumed here: even ones are
                // held, odd ones close a cross product component.
                if (step_reg != 5'd0)
                begin
                    if (!p[0])
                    begin
                        tmp_next = prod_reg[PROD_W-1:0];
                    end
                    else
                    begin
                        mag_next[p[2:1]]  = mag_of(cr);
                        sign_next[p[2:1]] = cr[VEC_W-1];
                    end
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd6)
                begin
                    state_next = S_MAG;
                end
            end
            S_RDACC:
            begin
                state_next = S_RDLD;
            end
            S_RDLD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    av = VEC_W'($signed(acc_rdata[i*ACC_W +: ACC_W]));
                    mag_next[i]  = mag_of(av);
                    sign_next[i] = av[VEC_W-1];
                end
                state_next = S_MAG;
            end
            S_MAG:
            begin
                m_next = m2;
                if (m2 == '0)
                begin
                    // A zero vector has a zero unit vector; a triangle adds nothing.
                    u_next[0]  = '0;
                    u_next[1]  = '0;
                    u_next[2]  = '0;
                    state_next = (kind_reg == KIND_TRI) ? S_IDLE : S_OUT;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (m_reg[VEC_W-1:30] != '0)
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (!m_reg[29])
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    n_next     = '0;
                    step_next  = 5'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (step_reg != 5'd0)
                begin
                    n_next = n_reg + prod_reg[SQ_W-1:0];
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    root_next  = '0;
                    bit_next   = {1'b1, {(SQ_W-1){1'b0}}};
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (n_reg >= trial_root)
                begin
                    n_next    = n_reg - trial_root;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    comp_next  = 2'd0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                // Quotient of (2*mag*16384 + len) / (2*len), known below 2^16.
                r_next     = LEN_W'(num[45:Q_W]);
                nlo_next   = num[Q_W-1:0];
                q_next     = '0;
                step_next  = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                r_next   = (trial >= dval) ? LEN_W'(trial - dval) : LEN_W'(trial);
                nlo_next = nlo_reg << 1;
                q_next   = qn;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd15)
                begin
                    u_next[comp_reg] = sign_sel ? -$signed(qc) : $signed(qc);
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = (kind_reg == KIND_TRI) ? S_ACCRD : S_OUT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_DIVI;
                    end
                end
            end
            S_ACCRD:
            begin
                state_next = S_ACCWR;
            end
            S_ACCWR:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_ACCRD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    normal_x_next  = u_reg[0];
                    normal_y_next  = u_reg[1];
                    normal_z_next  = u_reg[2];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state. Reset starts the zeroing pass over the accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            comp_reg      <= '0;
            kind_reg      <= KIND_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            comp_reg      <= comp_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        corner_reg   <= corner_next;
        pa_reg       <= pa_next;
        e1_reg       <= e1_next;
        e2_reg       <= e2_next;
        prod_reg     <= prod_next;
        tmp_reg      <= tmp_next;
        mag_reg      <= mag_next;
        sign_reg     <= sign_next;
        m_reg        <= m_next;
        n_reg        <= n_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        r_reg        <= r_next;
        nlo_reg      <= nlo_next;
        q_reg        <= q_next;
        u_reg        <= u_next;
        normal_x_reg <= normal_x_next;
        normal_y_reg <= normal_y_next;
        normal_z_reg <= normal_z_next;
    end

    // The vector length after normalization is at least 2^29.
    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVI) |-> (root_reg[LEN_W-1:29] != 3'd0))
        else $error("vector length below normalized floor");

    // The partial remainder stays below the divisor.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (r_reg < {root_reg[LEN_W-2:0], 1'b0}))
        else $error("division remainder out of range");

    // Squaring starts only with the largest magnitude inside [2^29, 2^30).
    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ) |-> ((m_reg[VEC_W-1:30] == '0) && m_reg[29]))
        else $error("squaring entered with unnormalized vector");

    // A result appears only from the output hand-off state.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output hand-off");

endmodule

### tb/mesh_vertex_normal_accumulator_tb.sv
// Self-checking testbench for mesh_vertex_normal_accumulator: a queue-fed driver,
// a checking monitor and a built-in predictor of the normal arithmetic.
// Depends on mvna_pkg and the block's RTL.
module mesh_vertex_normal_accumulator_tb;
    import mvna_pkg::*;

    localparam int NUM_VERTS   = 256;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 400;

    typedef struct {
        kind_t                     kind;
        logic [IDX_W-1:0]          a;
        logic [IDX_W-1:0]          b;
        logic [IDX_W-1:0]          c;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        bit                        hold_until_idle;
    } mesh_op_t;

    typedef struct {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = '0;
    logic [IDX_W-1:0] vertex_index = '0;
    logic [IDX_W-1:0] second_index = '0;
    logic [IDX_W-1:0] third_index = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic signed [COORD_W-1:0] coord_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;

    mesh_op_t pending_ops[$];
    normal_t  expected_normals[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    bit       gaps_on = 1'b1;

    // Predictor state: vertex positions and the saturating normal sums.
    longint pos_x[NUM_VERTS];
    longint pos_y[NUM_VERTS];
    longint pos_z[NUM_VERTS];
    int     sum_x[NUM_VERTS];
    int     sum_y[NUM_VERTS];
    int     sum_z[NUM_VERTS];

    // Generator-side record of which vertices hold a position, so that no
    // triangle ever touches a vertex that was never loaded.
    bit written[NUM_VERTS];
    int loaded_list[$];

    mesh_vertex_normal_accumulator #(.MAX_VERTICES(NUM_VERTS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .vertex_index(vertex_index),
        .second_index(second_index), .third_index(third_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Scale a vector to unit length in Q2.14: normalize the largest magnitude
    // into [2^29, 2^30), take the floor root of the sum of squares, then
    // divide each component with rounding half away from zero.
    function automatic normal_t unit_normal(longint vx, longint vy, longint vz);
        longint          comp[3];
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        int              left;
        int              right;
        int              res[3];
        normal_t         n;
        comp[0] = vx;
        comp[1] = vy;
        comp[2] = vz;
        peak = 0;
        left = 0;
        right = 0;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = comp[i] < 0 ? longint'(-comp[i]) : longint'(comp[i]);
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            n.x = '0;
            n.y = '0;
            n.z = '0;
            return n;
        end
        while (peak >= (64'd1 << 30))
        begin
            peak = peak >> 1;
            right++;
        end
        while (peak < (64'd1 << 29))
        begin
            peak = peak << 1;
            left++;
        end
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (mag[i] >> right) << left;
            sq = sq + mag[i] * mag[i];
        end
        len = floor_sqrt(sq);
        for (int i = 0; i < 3; i++)
        begin
            q = (2 * mag[i] * 16384 + len) / (2 * len);
            if (q > 16384)
                q = 16384;
            res[i] = comp[i] < 0 ? -int'(q) : int'(q);
        end
        n.x = NRM_W'(res[0]);
        n.y = NRM_W'(res[1]);
        n.z = NRM_W'(res[2]);
        return n;
    endfunction

    function automatic int clamp_sum(int acc, int d);
        int r;
        r = acc - d;
        if (r > 2097151)
            r = 2097151;
        if (r < -2097152)
            r = -2097152;
        return r;
    endfunction

    // Apply one accepted transaction to the predictor; reads queue a result.
    task automatic apply_mesh_op(mesh_op_t op);
        longint  e1[3];
        longint  e2[3];
        int      corner[3];
        normal_t u;
        case (op.kind)
            KIND_LOAD:
            begin
                pos_x[op.a] = op.x;
                pos_y[op.a] = op.y;
                pos_z[op.a] = op.z;
            end
            KIND_TRI:
            begin
                e1[0] = pos_x[op.b] - pos_x[op.a];
                e1[1] = pos_y[op.b] - pos_y[op.a];
                e1[2] = pos_z[op.b] - pos_z[op.a];
                e2[0] = pos_x[op.c] - pos_x[op.a];
                e2[1] = pos_y[op.c] - pos_y[op.a];
                e2[2] = pos_z[op.c] - pos_z[op.a];
                u = unit_normal(e1[1] * e2[2] - e1[2] * e2[1],
                                e1[2] * e2[0] - e1[0] * e2[2],
                                e1[0] * e2[1] - e1[1] * e2[0]);
                corner[0] = op.a;
                corner[1] = op.b;
                corner[2] = op.c;
                // A degenerate triangle gives a zero vector and so changes nothing.
                for (int i = 0; i < 3; i++)
                begin
                    sum_x[corner[i]] = clamp_sum(sum_x[corner[i]], u.x);
                    sum_y[corner[i]] = clamp_sum(sum_y[corner[i]], u.y);
                    sum_z[corner[i]] = clamp_sum(sum_z[corner[i]], u.z);
                end
            end
            KIND_READ:
            begin
                u = unit_normal(sum_x[op.a], sum_y[op.a], sum_z[op.a]);
                expected_normals = {expected_normals, u};
            end
            default:
            begin
                foreach (sum_x[i])
                begin
                    sum_x[i] = 0;
                    sum_y[i] = 0;
                    sum_z[i] = 0;
                end
            end
        endcase
    endtask

    task automatic queue_op(kind_t k, int a, int b, int c, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                            bit hold = 1'b0);
        mesh_op_t op;
        op.kind = k;
        op.a = IDX_W'(a);
        op.b = IDX_W'(b);
        op.c = IDX_W'(c);
        op.x = x;
        op.y = y;
        op.z = z;
        op.hold_until_idle = hold;
        if (k == KIND_LOAD && !written[a])
        begin
            written[a] = 1'b1;
            loaded_list = {loaded_list, a};
        end
        pending_ops = {pending_ops, op};
    endtask

    task automatic queue_load(int a, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        queue_op(KIND_LOAD, a, $urandom, $urandom, x, y, z);
    endtask

    task automatic queue_tri(int a, int b, int c, bit hold = 1'b0);
        queue_op(KIND_TRI, a, b, c, COORD_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom), hold);
    endtask

    task automatic queue_read(int a);
        queue_op(KIND_READ, a, $urandom, $urandom, COORD_W'($urandom),
                 COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic queue_clear();
        queue_op(KIND_CLEAR, $urandom, $urandom, $urandom, COORD_W'($urandom),
                 COORD_W'($urandom), COORD_W'($urandom));
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        // Small meshes mostly, with full-range values now and then.
        if ($urandom_range(0, 4) == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    // Stimulus: directed corner cases, then random phases with a saturation run.
    initial
    begin
        int r;
        int pick[3];
        queue_load(0, 0, 0, 0);
        queue_load(1, 256, 0, 0);
        queue_load(2, 0, 256, 0);
        queue_tri(0, 1, 2);
        queue_read(0);
        queue_load(3, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        queue_load(4, 24'sh800000, 24'sh800000, 24'sh800000);
        queue_load(5, 24'sh800000, 24'sh7FFFFF, 0);
        queue_tri(3, 4, 5);
        queue_tri(0, 0, 1);                 // repeated corner
        queue_load(6, 512, 0, 0);
        queue_tri(0, 1, 6);                 // collinear corners
        queue_load(255, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        queue_tri(255, 3, 4);
        queue_read(1);
        queue_read(3);
        queue_read(255);
        queue_read(254);                    // never accumulated: zero normal
        queue_clear();
        queue_read(0);
        queue_tri(2, 1, 0);
        queue_read(2);

        // Random phases; a phase that opens with a triangle first waits for all
        // reads to come back, and so does the saturation run.
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int n = 0; n < 95; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    queue_load($urandom_range(0, NUM_VERTS - 1), rand_coord(),
                               rand_coord(), rand_coord());
                else if (r < 62)
                begin
                    foreach (pick[i])
                        pick[i] = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                    queue_tri(pick[0], pick[1], pick[2], n == 0);
                end
                else if (r < 96)
                    queue_read($urandom_range(0, NUM_VERTS - 1));
                else
                    queue_clear();
            end
            if (phase == 2)
            begin
                // Drive one accumulator into each saturation limit.
                queue_load(10, 0, 0, 0);
                queue_load(11, 0, 256, 0);
                queue_load(12, 0, 0, 256);
                queue_clear();
                for (int n = 0; n < 132; n++)
                    queue_tri(10, 11, 12, n == 0);
                queue_read(10);
                queue_clear();
                for (int n = 0; n < 132; n++)
                    queue_tri(10, 12, 11);
                queue_read(10);
                queue_read(11);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !in_valid && expected_normals.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_normals.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Driver: presents the next queued transaction and holds it while stalled.
    // All next values are worked out first so each signal gets one assignment.
    int send_gap = 0;
    always @(posedge clk)
    begin
        mesh_op_t nxt;
        logic     next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                apply_mesh_op(pending_ops.pop_front());
                next_valid = 1'b0;
                send_gap = pick_gap();
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_ops.size() > 0 &&
                         (!pending_ops[0].hold_until_idle || expected_normals.size() == 0))
                begin
                    nxt = pending_ops[0];
                    next_valid = 1'b1;
                    kind <= nxt.kind;
                    vertex_index <= nxt.a;
                    second_index <= nxt.b;
                    third_index <= nxt.c;
                    coord_x <= nxt.x;
                    coord_y <= nxt.y;
                    coord_z <= nxt.z;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: checks each accepted result against the oldest expectation and
    // drives random stalls on the output channel.
    int recv_gap = 0;
    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_normals.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d %0d %0d", normal_x, normal_y,
                                 normal_z);
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (want.x !== normal_x || want.y !== normal_y || want.z !== normal_z)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("normal mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.x, want.y, want.z, normal_x, normal_y, normal_z);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                recv_gap = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // Timeout, and a periodic chance of a stretch with no gaps.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 300 == 0)
            gaps_on <= ($urandom_range(0, 3) != 0);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
